FILE: hw/rtl/pet_pkg.sv
`timescale 1ns / 1ps

package pet_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int FUNC_W   = 8;
	localparam int REG_W    = 16;
	localparam int UNIT_W   = 8;
	localparam int KEY_W    = FUNC_W + REG_W + UNIT_W;
	localparam int SEC_W    = 32;
	localparam int NSEC_W   = 30;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD = 2'd0,
		MODE_DEL = 2'd1,
		MODE_CLR = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_LOWERED   = 3'd1,
		STAT_KEPT      = 3'd2,
		STAT_DELETED   = 3'd3,
		STAT_NOT_FOUND = 3'd4,
		STAT_FULL      = 3'd5,
		STAT_CLEARED   = 3'd6
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SEC_W-1:0]  psec;
		logic [NSEC_W-1:0] pnsec;
		logic [SEC_W-1:0]  dsec;
		logic [NSEC_W-1:0] dnsec;
	} entry_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic exec;
	} pet_cmd_t;

	typedef struct packed {
		logic scan_done;
	} pet_sts_t;

endpackage

FILE: hw/rtl/poll_entry_table.sv
// Add and delete scan the table between transfer in and result valid: one read per slot
// from the entry memory, a compare of each read against the request key, then execute;
// a key found in slot k ends the scan early.
// Clear and the unused mode skip the scan; a new request is taken in the cycle after execute.
// One request in work at a time; a waiting result holds execute. Reset clears valid marks.
`timescale 1ns / 1ps

module poll_entry_table #(
	parameter int TABLE_ENTRIES = pet_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pet_pkg::MODE_W-1:0]    mode,
	input  logic [pet_pkg::FUNC_W-1:0]    func_code,
	input  logic [pet_pkg::REG_W-1:0]     reg_addr,
	input  logic [pet_pkg::UNIT_W-1:0]    unit_id,
	input  logic [pet_pkg::SEC_W-1:0]     period_sec,
	input  logic [pet_pkg::NSEC_W-1:0]    period_nsec,
	input  logic [pet_pkg::SEC_W-1:0]     due_sec,
	input  logic [pet_pkg::NSEC_W-1:0]    due_nsec,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pet_pkg::STATUS_W-1:0]  status,
	output logic [pet_pkg::SLOT_W-1:0]    slot,
	output logic [pet_pkg::SEC_W-1:0]     stored_period_sec,
	output logic [pet_pkg::NSEC_W-1:0]    stored_period_nsec,
	output logic [pet_pkg::SEC_W-1:0]     stored_due_sec,
	output logic [pet_pkg::NSEC_W-1:0]    stored_due_nsec
);
	import pet_pkg::*;

	pet_cmd_t cmd;
	pet_sts_t sts;

	pet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pet_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.mode               (mode),
		.func_code          (func_code),
		.reg_addr           (reg_addr),
		.unit_id            (unit_id),
		.period_sec         (period_sec),
		.period_nsec        (period_nsec),
		.due_sec            (due_sec),
		.due_nsec           (due_nsec),
		.status             (status),
		.slot               (slot),
		.stored_period_sec  (stored_period_sec),
		.stored_period_nsec (stored_period_nsec),
		.stored_due_sec     (stored_due_sec),
		.stored_due_nsec    (stored_due_nsec)
	);

endmodule

FILE: hw/rtl/pet_dp.sv
`timescale 1ns / 1ps

module pet_dp #(
	parameter int TABLE_ENTRIES = pet_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pet_pkg::pet_cmd_t             cmd,
	output pet_pkg::pet_sts_t             sts,
	input  logic [pet_pkg::MODE_W-1:0]    mode,
	input  logic [pet_pkg::FUNC_W-1:0]    func_code,
	input  logic [pet_pkg::REG_W-1:0]     reg_addr,
	input  logic [pet_pkg::UNIT_W-1:0]    unit_id,
	input  logic [pet_pkg::SEC_W-1:0]     period_sec,
	input  logic [pet_pkg::NSEC_W-1:0]    period_nsec,
	input  logic [pet_pkg::SEC_W-1:0]     due_sec,
	input  logic [pet_pkg::NSEC_W-1:0]    due_nsec,
	output logic [pet_pkg::STATUS_W-1:0]  status,
	output logic [pet_pkg::SLOT_W-1:0]    slot,
	output logic [pet_pkg::SEC_W-1:0]     stored_period_sec,
	output logic [pet_pkg::NSEC_W-1:0]    stored_period_nsec,
	output logic [pet_pkg::SEC_W-1:0]     stored_due_sec,
	output logic [pet_pkg::NSEC_W-1:0]    stored_due_nsec
);
	import pet_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);

	entry_t mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [MODE_W-1:0] req_mode_q;
	logic [KEY_W-1:0]  req_key_q;
	logic [SEC_W-1:0]  req_psec_q;
	logic [NSEC_W-1:0] req_pnsec_q;
	logic [SEC_W-1:0]  req_dsec_q;
	logic [NSEC_W-1:0] req_dnsec_q;

	logic [CW-1:0] cnt_q;
	entry_t        rd_s1;
	logic [IW-1:0] idx_s1;
	logic          tag_s1;
	logic          vld_s1;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	entry_t        hit_ent_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;

	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	entry_t              res_q;

	logic          issue_ok;
	logic [IW-1:0] issue_idx;
	logic          take_free;
	logic          match_now;
	logic          lower;

	logic          wr_en;
	logic [IW-1:0] wr_idx;
	entry_t        wr_ent;
	logic          set_valid;
	logic          clr_valid;
	logic          clr_all;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]   res_slot;
	entry_t              res_ent;

	assign issue_ok  = cmd.issue && (cnt_q != CNT_END);
	assign issue_idx = cnt_q[IW-1:0];
	assign take_free = issue_ok && !valid_q[issue_idx] && !free_found_q;
	assign match_now = vld_s1 && tag_s1 && !hit_q && (rd_s1.key == req_key_q);
	assign sts.scan_done = match_now || (cnt_q == CNT_END);

	assign lower = (req_psec_q < hit_ent_q.psec) ||
		((req_psec_q == hit_ent_q.psec) && (req_pnsec_q < hit_ent_q.pnsec));

	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = hit_idx_q;
		wr_ent     = '{key: req_key_q, psec: req_psec_q, pnsec: req_pnsec_q,
			dsec: '0, dnsec: '0};
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		clr_all    = 1'b0;
		res_status = STAT_NOT_FOUND;
		res_slot   = '0;
		res_ent    = '0;
		unique case (req_mode_q)
			MODE_ADD: begin
				if (hit_q) begin
					res_slot = SLOT_W'(hit_idx_q);
					if (lower) begin
						wr_en      = 1'b1;
						res_status = STAT_LOWERED;
						res_ent    = wr_ent;
					end else begin
						res_status = STAT_KEPT;
						res_ent    = hit_ent_q;
					end
				end else if (free_found_q) begin
					wr_en        = 1'b1;
					wr_idx       = free_idx_q;
					wr_ent.dsec  = req_dsec_q;
					wr_ent.dnsec = req_dnsec_q;
					set_valid    = 1'b1;
					res_status   = STAT_INSERTED;
					res_slot     = SLOT_W'(free_idx_q);
					res_ent      = wr_ent;
				end else begin
					res_status = STAT_FULL;
				end
			end
			MODE_DEL: begin
				if (hit_q) begin
					clr_valid  = 1'b1;
					res_status = STAT_DELETED;
					res_slot   = SLOT_W'(hit_idx_q);
					res_ent    = hit_ent_q;
				end
			end
			MODE_CLR: begin
				clr_all    = 1'b1;
				res_status = STAT_CLEARED;
			end
			default: begin
				res_status = STAT_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (issue_ok) begin
			rd_s1 <= mem[issue_idx];
		end
		if (cmd.exec && wr_en) begin
			mem[wr_idx] <= wr_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_mode_q  <= mode;
			req_key_q   <= {func_code, reg_addr, unit_id};
			req_psec_q  <= period_sec;
			req_pnsec_q <= period_nsec;
			req_dsec_q  <= due_sec;
			req_dnsec_q <= due_nsec;
		end
		if (issue_ok) begin
			idx_s1 <= issue_idx;
			tag_s1 <= valid_q[issue_idx];
		end
		if (take_free && !cmd.load) begin
			free_idx_q <= issue_idx;
		end
		if (match_now && !cmd.load) begin
			hit_idx_q <= idx_s1;
			hit_ent_q <= rd_s1;
		end
		if (cmd.exec) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			res_q    <= res_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q        <= '0;
				vld_s1       <= 1'b0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					vld_s1 <= issue_ok;
				end
				if (issue_ok) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (take_free) begin
					free_found_q <= 1'b1;
				end
				if (match_now) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.exec) begin
				if (clr_all) begin
					valid_q <= '0;
				end else if (set_valid) begin
					valid_q[wr_idx] <= 1'b1;
				end else if (clr_valid) begin
					valid_q[hit_idx_q] <= 1'b0;
				end
			end
		end
	end

	assign status             = status_q;
	assign slot               = slot_q;
	assign stored_period_sec  = res_q.psec;
	assign stored_period_nsec = res_q.pnsec;
	assign stored_due_sec     = res_q.dsec;
	assign stored_due_nsec    = res_q.dnsec;

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && hit_q |-> valid_q[hit_idx_q])
		else $error("matched slot is not valid at execute");

	a_free_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && !hit_q && free_found_q |-> !valid_q[free_idx_q])
		else $error("chosen free slot is already valid");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && req_mode_q == MODE_CLR |=> valid_q == '0)
		else $error("clear left valid slots");

endmodule

FILE: hw/rtl/pet_ctrl.sv
`timescale 1ns / 1ps

module pet_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pet_pkg::MODE_W-1:0] mode,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  pet_pkg::pet_sts_t          sts,
	output pet_pkg::pet_cmd_t          cmd
);
	import pet_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   needs_scan;

	assign in_ready   = (state_q == ST_IDLE);
	assign needs_scan = (mode == MODE_ADD) || (mode == MODE_DEL);

	assign cmd.load  = in_valid && in_ready;
	assign cmd.issue = (state_q == ST_SCAN);
	assign cmd.exec  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= needs_scan ? ST_SCAN : ST_EXEC;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_exec_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("execute did not present a result");

	a_scan_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && sts.scan_done |=> state_q == ST_EXEC)
		else $error("finished scan did not move to execute");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !out_valid_q || out_ready)
		else $error("result overwritten before transfer");

endmodule

FILE: tb/poll_entry_table_tb.sv
`timescale 1ns / 1ps

module poll_entry_table_tb;
	import pet_pkg::*;

	localparam int N_SLOTS = TABLE_ENTRIES_DEF;
	localparam int N_SCRIPT = 25;
	localparam int N_RANDOM = 800;
	localparam int N_POOL = 24;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
		logic [SEC_W-1:0]  psec;
		logic [NSEC_W-1:0] pnsec;
		logic [SEC_W-1:0]  dsec;
		logic [NSEC_W-1:0] dnsec;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [SEC_W-1:0]    psec;
		logic [NSEC_W-1:0]   pnsec;
		logic [SEC_W-1:0]    dsec;
		logic [NSEC_W-1:0]   dnsec;
	} outcome_t;

	typedef struct {
		request_t req;
		bit       known;
		outcome_t want;
	} script_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [MODE_W-1:0]    mode = '0;
	logic [FUNC_W-1:0]    func_code = '0;
	logic [REG_W-1:0]     reg_addr = '0;
	logic [UNIT_W-1:0]    unit_id = '0;
	logic [SEC_W-1:0]     period_sec = '0;
	logic [NSEC_W-1:0]    period_nsec = '0;
	logic [SEC_W-1:0]     due_sec = '0;
	logic [NSEC_W-1:0]    due_nsec = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [SLOT_W-1:0]    slot;
	logic [SEC_W-1:0]     stored_period_sec;
	logic [NSEC_W-1:0]    stored_period_nsec;
	logic [SEC_W-1:0]     stored_due_sec;
	logic [NSEC_W-1:0]    stored_due_nsec;

	bit          slot_used[N_SLOTS];
	entry_t      slot_entry[N_SLOTS];
	outcome_t    pending_results[$];
	logic [31:0] key_pool[N_POOL];
	script_row_t script[N_SCRIPT];
	bit          no_idle = 1'b0;
	int          mismatch_count = 0;

	poll_entry_table u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.mode               (mode),
		.func_code          (func_code),
		.reg_addr           (reg_addr),
		.unit_id            (unit_id),
		.period_sec         (period_sec),
		.period_nsec        (period_nsec),
		.due_sec            (due_sec),
		.due_nsec           (due_nsec),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.slot               (slot),
		.stored_period_sec  (stored_period_sec),
		.stored_period_nsec (stored_period_nsec),
		.stored_due_sec     (stored_due_sec),
		.stored_due_nsec    (stored_due_nsec)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic request_t mk_req(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
			input logic [SEC_W-1:0] ps, input logic [NSEC_W-1:0] pn,
			input logic [SEC_W-1:0] ds, input logic [NSEC_W-1:0] dn);
		request_t r;
		r = '{m, k, ps, pn, ds, dn};
		return r;
	endfunction

	function automatic outcome_t view_slot(input logic [STATUS_W-1:0] st, input int idx);
		outcome_t o;
		o.status = st;
		o.slot = idx[SLOT_W-1:0];
		o.psec = slot_entry[idx].psec;
		o.pnsec = slot_entry[idx].pnsec;
		o.dsec = slot_entry[idx].dsec;
		o.dnsec = slot_entry[idx].dnsec;
		return o;
	endfunction

	function automatic outcome_t update_table(input request_t r);
		outcome_t o;
		int hit;
		int free_slot;
		o = '0;
		hit = -1;
		free_slot = -1;
		for (int i = N_SLOTS - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_entry[i].key == r.key)
				hit = i;
			if (!slot_used[i])
				free_slot = i;
		end
		case (r.mode)
			MODE_ADD: begin
				if (hit >= 0) begin
					if (r.psec < slot_entry[hit].psec ||
							(r.psec == slot_entry[hit].psec && r.pnsec < slot_entry[hit].pnsec)) begin
						slot_entry[hit].psec = r.psec;
						slot_entry[hit].pnsec = r.pnsec;
						slot_entry[hit].dsec = '0;
						slot_entry[hit].dnsec = '0;
						o = view_slot(STAT_LOWERED, hit);
					end else begin
						o = view_slot(STAT_KEPT, hit);
					end
				end else if (free_slot < 0) begin
					o.status = STAT_FULL;
				end else begin
					slot_used[free_slot] = 1'b1;
					slot_entry[free_slot] = '{r.key, r.psec, r.pnsec, r.dsec, r.dnsec};
					o = view_slot(STAT_INSERTED, free_slot);
				end
			end
			MODE_DEL: begin
				if (hit < 0) begin
					o.status = STAT_NOT_FOUND;
				end else begin
					slot_used[hit] = 1'b0;
					o = view_slot(STAT_DELETED, hit);
				end
			end
			MODE_CLR: begin
				slot_used = '{default: 1'b0};
				o.status = STAT_CLEARED;
			end
			default: begin
				o.status = STAT_NOT_FOUND;
			end
		endcase
		return o;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			r.mode = MODE_ADD;
		else if (pick < 96)
			r.mode = MODE_DEL;
		else if (pick < 98)
			r.mode = MODE_CLR;
		else
			r.mode = MODE_UNUSED;
		if ($urandom_range(0, 6) == 0)
			r.key = $urandom;
		else
			r.key = key_pool[$urandom_range(0, N_POOL - 1)];
		if ($urandom_range(0, 1)) begin
			r.psec = $urandom;
			r.pnsec = NSEC_W'($urandom);
		end else begin
			r.psec = $urandom_range(0, 3);
			r.pnsec = NSEC_W'($urandom_range(0, 3));
		end
		r.dsec = $urandom;
		r.dnsec = NSEC_W'($urandom);
		return r;
	endfunction

	task automatic send_request(input request_t r, output outcome_t predicted);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= r.mode;
		func_code <= r.key[31:24];
		reg_addr <= r.key[23:8];
		unit_id <= r.key[7:0];
		period_sec <= r.psec;
		period_nsec <= r.pnsec;
		due_sec <= r.dsec;
		due_nsec <= r.dnsec;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predicted = update_table(r);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	initial begin
		outcome_t want;
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				$display("%0t: result with status %0d arrived with none pending", $time, status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("slot", 32'(want.slot), 32'(slot));
				check_field("stored_period_sec", want.psec, stored_period_sec);
				check_field("stored_period_nsec", 32'(want.pnsec), 32'(stored_period_nsec));
				check_field("stored_due_sec", want.dsec, stored_due_sec);
				check_field("stored_due_nsec", 32'(want.dnsec), 32'(stored_due_nsec));
			end
		end
	end

	initial begin
		outcome_t predicted;
		for (int i = 0; i < N_POOL; i++)
			key_pool[i] = $urandom;

		script[0].req = mk_req(MODE_DEL, 32'h0123_4567, '0, '0, '0, '0);
		script[0].known = 1'b1;
		script[0].want = '{STAT_NOT_FOUND, 4'd0, 32'd0, 30'd0, 32'd0, 30'd0};
		script[1].req = mk_req(MODE_UNUSED, '1, '1, '1, '1, '1);
		script[1].known = 1'b1;
		script[1].want = '{STAT_NOT_FOUND, 4'd0, 32'd0, 30'd0, 32'd0, 30'd0};
		script[2].req = mk_req(MODE_ADD, '1, '1, '1, '1, '1);
		script[2].known = 1'b1;
		script[2].want = '{STAT_INSERTED, 4'd0, 32'hffff_ffff, 30'h3fff_ffff,
			32'hffff_ffff, 30'h3fff_ffff};
		script[3].req = mk_req(MODE_ADD, '1, '1, 30'h3fff_fffe, '1, '1);
		script[3].known = 1'b1;
		script[3].want = '{STAT_LOWERED, 4'd0, 32'hffff_ffff, 30'h3fff_fffe, 32'd0, 30'd0};
		script[4].req = script[3].req;
		script[4].known = 1'b1;
		script[4].want = '{STAT_KEPT, 4'd0, 32'hffff_ffff, 30'h3fff_fffe, 32'd0, 30'd0};
		script[5].req = mk_req(MODE_ADD, '0, '0, '0, '0, '0);
		script[5].known = 1'b1;
		script[5].want = '{STAT_INSERTED, 4'd1, 32'd0, 30'd0, 32'd0, 30'd0};
		script[6].req = mk_req(MODE_DEL, '1, '0, '0, '0, '0);
		script[6].known = 1'b1;
		script[6].want = '{STAT_DELETED, 4'd0, 32'hffff_ffff, 30'h3fff_fffe, 32'd0, 30'd0};
		script[7].req = mk_req(MODE_CLR, 32'h1234_5678, '0, '0, '0, '0);
		script[7].known = 1'b1;
		script[7].want = '{STAT_CLEARED, 4'd0, 32'd0, 30'd0, 32'd0, 30'd0};
		for (int i = 0; i < N_SLOTS; i++)
			script[8 + i].req = mk_req(MODE_ADD,
				{i[7:0], 16'ha5a5 ^ i[15:0], 8'hff - i[7:0]}, i, 30'd999_999_999,
				$urandom, NSEC_W'($urandom));
		script[24].req = mk_req(MODE_ADD, 32'h7e57_c0de, 32'd5, 30'd5, 32'd5, 30'd5);
		script[24].known = 1'b1;
		script[24].want = '{STAT_FULL, 4'd0, 32'd0, 30'd0, 32'd0, 30'd0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_SCRIPT; i++) begin
			send_request(script[i].req, predicted);
			pending_results.push_back(script[i].known ? script[i].want : predicted);
		end
		drain_results();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			send_request(random_request(), predicted);
			pending_results.push_back(predicted);
			if (i % 250 == 249)
				drain_results();
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
